>>> rtl/pmk_pkg.sv
// Shared types and constants of the polar Morton key generator.
// No dependencies; every other file imports this package.
package pmk_pkg;

  // CORDIC datapath widths: x/y with 16 guard bits, angle in Q.30 radians
  localparam int CW         = 51;
  localparam int ZW         = 35;
  localparam int ROOT_STEPS = 32;
  localparam int FIFO_DEPTH = 4;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] ROUND_Q14   = 35'sd8192;

  // z lanes of the interleaved key
  localparam logic [62:0] Z_LANE_MASK = 63'h1249249249249249;

  typedef enum logic [2:0] {
    CFG_KEY_MODE    = 3'd0,
    CFG_NORM_FACTOR = 3'd1,
    CFG_CORNER_PHI  = 3'd2,
    CFG_CORNER_R    = 3'd3,
    CFG_CORNER_Z    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic               key_mode;
    logic        [31:0] norm_factor;
    logic signed [31:0] corner_phi;
    logic signed [31:0] corner_r;
    logic signed [31:0] corner_z;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] particle_index;
    logic               last_item;
  } in_word_t;

  typedef struct packed {
    logic [62:0] morton_key;
    logic [31:0] key_index;
    logic        key_last;
    logic        clamped;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                  zero_vec;
    logic signed [32:0]    cx;
    logic signed [32:0]    cy;
    logic signed [ZW-1:0]  z0;
    logic        [63:0]    sq_x;
    logic        [63:0]    sq_y;
    logic signed [31:0]    pos_z;
    logic        [31:0]    idx;
    logic                  last;
  } fb_word_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      5'd24: v = 31'd64;
      5'd25: v = 31'd32;
      5'd26: v = 31'd16;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/polar_morton_key_generator.sv
// Top level of the polar Morton key generator: configuration registers,
// front classifier, queue and back pipeline. Depends on pmk_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------
//  in       | in_valid / in_ready   | in_data  (pos_x/y/z, index, last)
//  out      | out_valid / out_ready | out_data (key, index, last, clamped)
//  cfg      | cfg_en                | cfg_index, cfg_data
//
// One word is accepted per cycle while the queue is not full; after the queue it passes
// the entry stage, 32 root/CORDIC stages, offset, scale and output registers.
// The 32-stage root unit, one root bit per stage, sets the latency.
// Synchronous reset clears valid bits, queue pointers and configuration registers to defaults.
// An output stall freezes the back pipeline; the queue keeps taking words
// until it holds four.
module polar_morton_key_generator import pmk_pkg::*; #(
  parameter int LEVEL_BITS   = 21,
  parameter int CORDIC_STEPS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_en,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t     cfg;
  fb_word_t fb_in, fb_out;
  logic     q_full, q_empty, q_pop;

  // write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_mode    <= 1'b0;
      cfg.norm_factor <= 32'd65536;
      cfg.corner_phi  <= '0;
      cfg.corner_r    <= '0;
      cfg.corner_z    <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_KEY_MODE:    cfg.key_mode    <= cfg_data[0];
        CFG_NORM_FACTOR: cfg.norm_factor <= cfg_data;
        CFG_CORNER_PHI:  cfg.corner_phi  <= cfg_data;
        CFG_CORNER_R:    cfg.corner_r    <= cfg_data;
        CFG_CORNER_Z:    cfg.corner_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  pmk_front u_front (
    .in_data (in_data),
    .fb      (fb_in)
  );

  pmk_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (in_valid && in_ready),
    .wdata (fb_in),
    .pop   (q_pop),
    .rdata (fb_out),
    .full  (q_full),
    .empty (q_empty)
  );

  pmk_back #(
    .LEVEL_BITS   (LEVEL_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fb        (fb_out),
    .fb_empty  (q_empty),
    .fb_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/pmk_front.sv
// Front end: classifies a position word (quadrant pre-rotation, zero vector)
// and squares |x| and |y| for the root unit. Depends on pmk_pkg.
module pmk_front import pmk_pkg::*; (
  input  in_word_t in_data,
  output fb_word_t fb
);

  logic [31:0] ax, ay;
  logic signed [32:0] xe, ye;

  // magnitudes and sign-extended coordinates
  assign ax = in_data.pos_x[31] ? 32'(-in_data.pos_x) : in_data.pos_x;
  assign ay = in_data.pos_y[31] ? 32'(-in_data.pos_y) : in_data.pos_y;
  assign xe = {in_data.pos_x[31], in_data.pos_x};
  assign ye = {in_data.pos_y[31], in_data.pos_y};

  // squares, and rotate left half-plane into the right one
  always_comb begin
    fb.zero_vec = (in_data.pos_x == '0) && (in_data.pos_y == '0);
    fb.sq_x     = 64'(ax) * 64'(ax);
    fb.sq_y     = 64'(ay) * 64'(ay);
    fb.pos_z    = in_data.pos_z;
    fb.idx      = in_data.particle_index;
    fb.last     = in_data.last_item;
    if (!in_data.pos_x[31]) begin
      fb.cx = xe;
      fb.cy = ye;
      fb.z0 = '0;
    end else if (!in_data.pos_y[31]) begin
      fb.cx = ye;
      fb.cy = -xe;
      fb.z0 = HALF_PI_Q30;
    end else begin
      fb.cx = -ye;
      fb.cy = xe;
      fb.z0 = -HALF_PI_Q30;
    end
  end

endmodule

>>> rtl/pmk_fifo.sv
// Short queue between front and back of the key generator.
// Depends on pmk_pkg for the word type and depth.
module pmk_fifo import pmk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fb_word_t wdata,
  input  logic     pop,
  output fb_word_t rdata,
  output logic     full,
  output logic     empty
);

  localparam int PW = $clog2(FIFO_DEPTH);

  fb_word_t      mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // store word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(FIFO_DEPTH)) else $error("fifo over depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("fifo count lost a push");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("pop from empty fifo");

endmodule

>>> rtl/pmk_back.sv
// Back end: CORDIC angle and exact root in lockstep stages, then corner
// offset, scaling, saturation and bit interleave. Depends on pmk_pkg.
module pmk_back import pmk_pkg::*; #(
  parameter int LEVEL_BITS   = 21,
  parameter int CORDIC_STEPS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  fb_word_t  fb,
  input  logic      fb_empty,
  output logic      fb_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int NST = ROOT_STEPS;
  localparam logic [33:0] TOP34 = 34'((64'(1) << LEVEL_BITS) - 1);

  logic adv;

  logic                 st_valid [0:NST];
  logic signed [CW-1:0] st_x     [0:NST];
  logic signed [CW-1:0] st_y     [0:NST];
  logic signed [ZW-1:0] st_z     [0:NST];
  logic        [63:0]   st_rem   [0:NST];
  logic        [63:0]   st_root  [0:NST];
  logic                 st_zero  [0:NST];
  logic signed [31:0]   st_pz    [0:NST];
  logic        [31:0]   st_idx   [0:NST];
  logic                 st_last  [0:NST];

  // whole pipeline moves when the output register is free or taken
  assign adv    = !out_valid || out_ready;
  assign fb_pop = adv && !fb_empty;

  // entry: scale to guard bits, sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= !fb_empty;
    end
    if (adv) begin
      st_x[0]    <= {{2{fb.cx[32]}}, fb.cx, 16'b0};
      st_y[0]    <= {{2{fb.cy[32]}}, fb.cy, 16'b0};
      st_z[0]    <= fb.z0;
      st_rem[0]  <= fb.sq_x + fb.sq_y;
      st_root[0] <= '0;
      st_zero[0] <= fb.zero_vec;
      st_pz[0]   <= fb.pos_z;
      st_idx[0]  <= fb.idx;
      st_last[0] <= fb.last;
    end
  end

  // one root bit per stage, one rotation in each of the first CORDIC_STEPS stages
  for (genvar k = 0; k < NST; k++) begin : g_step
    localparam logic [63:0] BITV = 64'(1) << (62 - 2*k);
    logic [64:0]          trial;
    logic                 fits;
    logic signed [CW-1:0] x_n, y_n;
    logic signed [ZW-1:0] z_n;

    assign trial = {1'b0, st_root[k]} + {1'b0, BITV};
    assign fits  = {1'b0, st_rem[k]} >= trial;

    if (k < CORDIC_STEPS) begin : g_rot
      localparam logic signed [ZW-1:0] ANG = {{(ZW-31){1'b0}}, atan_q30(5'(k))};
      logic signed [CW-1:0] xs, ys;
      assign xs = st_x[k] >>> k;
      assign ys = st_y[k] >>> k;
      always_comb begin
        if (!st_y[k][CW-1]) begin
          x_n = st_x[k] + ys;
          y_n = st_y[k] - xs;
          z_n = st_z[k] + ANG;
        end else begin
          x_n = st_x[k] - ys;
          y_n = st_y[k] + xs;
          z_n = st_z[k] - ANG;
        end
      end
    end else begin : g_hold
      assign x_n = st_x[k];
      assign y_n = st_y[k];
      assign z_n = st_z[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (adv) begin
        st_valid[k+1] <= st_valid[k];
      end
      if (adv) begin
        st_x[k+1]    <= x_n;
        st_y[k+1]    <= y_n;
        st_z[k+1]    <= z_n;
        st_rem[k+1]  <= fits ? st_rem[k] - trial[63:0] : st_rem[k];
        st_root[k+1] <= fits ? (st_root[k] >> 1) + BITV : st_root[k] >> 1;
        st_zero[k+1] <= st_zero[k];
        st_pz[k+1]   <= st_pz[k];
        st_idx[k+1]  <= st_idx[k];
        st_last[k+1] <= st_last[k];
      end
    end
  end

  // wrap and round angle, subtract corners
  logic signed [ZW-1:0] zw, pr;
  logic [19:0] phi_u;
  logic [33:0] d [3];
  logic [32:0] mag [3];

  always_comb begin
    zw = st_z[NST][ZW-1] ? st_z[NST] + TWO_PI_Q30 : st_z[NST];
    if (zw[ZW-1]) begin
      zw = '0;
    end
    pr    = zw + ROUND_Q14;
    phi_u = st_zero[NST] ? '0 : pr[33:14];
    d[0]  = {14'b0, phi_u} - {{2{cfg.corner_phi[31]}}, cfg.corner_phi};
    d[1]  = {2'b0, st_root[NST][31:0]} - {{2{cfg.corner_r[31]}}, cfg.corner_r};
    d[2]  = {{2{st_pz[NST][31]}}, st_pz[NST]} - {{2{cfg.corner_z[31]}}, cfg.corner_z};
    for (int j = 0; j < 3; j++) begin
      mag[j] = d[j][33] ? 33'(-d[j]) : d[j][32:0];
    end
  end

  logic        f_valid, f_last;
  logic [31:0] f_idx;
  logic        f_neg [3];
  logic [32:0] f_m   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= st_valid[NST];
    end
    if (adv) begin
      f_idx  <= st_idx[NST];
      f_last <= st_last[NST];
      for (int j = 0; j < 3; j++) begin
        f_neg[j] <= d[j][33];
        f_m[j]   <= mag[j];
      end
    end
  end

  // scale: split the factor into halves
  logic        m_valid, m_last;
  logic [31:0] m_idx;
  logic        m_neg [3];
  logic [48:0] m_hi  [3];
  logic [48:0] m_lo  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= f_valid;
    end
    if (adv) begin
      m_idx  <= f_idx;
      m_last <= f_last;
      for (int j = 0; j < 3; j++) begin
        m_neg[j] <= f_neg[j];
        m_hi[j]  <= 49'(f_m[j]) * 49'(cfg.norm_factor[31:16]);
        m_lo[j]  <= 49'(f_m[j]) * 49'(cfg.norm_factor[15:0]);
      end
    end
  end

  // saturate and interleave
  logic [49:0]           s   [3];
  logic [33:0]           q   [3];
  logic [LEVEL_BITS-1:0] qv  [3];
  logic                  cl  [3];
  logic [62:0]           key;
  logic                  clamp;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s[j] = {1'b0, m_hi[j]} + {17'b0, m_lo[j][48:16]};
      q[j] = s[j][49:16];
      if (m_neg[j]) begin
        qv[j] = '0;
        cl[j] = (q[j] != '0);
      end else if (q[j] > TOP34) begin
        qv[j] = '1;
        cl[j] = 1'b1;
      end else begin
        qv[j] = q[j][LEVEL_BITS-1:0];
        cl[j] = 1'b0;
      end
    end
    key = '0;
    for (int i = 0; i < LEVEL_BITS; i++) begin
      key[3*i+2] = qv[0][i];
      key[3*i+1] = qv[1][i];
      key[3*i]   = qv[2][i] && !cfg.key_mode;
    end
    clamp = cl[0] || cl[1] || (cl[2] && !cfg.key_mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m_valid;
    end
    if (adv) begin
      out_data.morton_key <= key;
      out_data.key_index  <= m_idx;
      out_data.key_last   <= m_last;
      out_data.clamped    <= clamp;
    end
  end

  a_root_exact: assert property (@(posedge clk) disable iff (rst)
    st_valid[NST] |-> st_rem[NST] <= {st_root[NST][62:0], 1'b0})
    else $error("root remainder too large");
  a_flat_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.key_mode |-> (out_data.morton_key & Z_LANE_MASK) == '0)
    else $error("z lanes set in 2D mode");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> m_valid == $past(m_valid) && f_valid == $past(f_valid))
    else $error("pipeline moved during stall");

endmodule
